### rtl/differential_steering_mixer_defines.svh
// Assertion macros shared by the differential steering mixer RTL.
`ifndef DIFFERENTIAL_STEERING_MIXER_DEFINES_SVH
`define DIFFERENTIAL_STEERING_MIXER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define DSM_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication that must hold a fixed number of cycles after the antecedent.
`define DSM_ASSERT_LATER(label, n, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##n (cons)) \
      else $error(msg);

`endif

### rtl/dsm_pkg.sv
// Types, constants and elaboration-time table functions for the steering mixer.
package dsm_pkg;

   // Configuration register indexes and reset values.
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 12;
   localparam logic [CSR_INDEX_W-1:0] CSR_WHEEL_LENGTH = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AXLE_LENGTH  = 4'd1;
   localparam logic [CSR_DATA_W-1:0]  WHEEL_LENGTH_RESET = 12'd56;
   localparam logic [CSR_DATA_W-1:0]  AXLE_LENGTH_RESET  = 12'd120;

   // Steering range and wheel speed limits.
   localparam logic signed [7:0] STEER_MAX = 8'sd90;
   localparam logic signed [7:0] STEER_MIN = -8'sd90;
   localparam int TAN_DEPTH = 91;
   localparam int TAN_IDX_W = $clog2(TAN_DEPTH);
   localparam int SPEED_MAX = 32767;
   localparam int SPEED_MIN = -32768;

   // Precision used to build the tangent table; covers the widest fraction.
   localparam int MAX_FRAC_BITS = 24;
   localparam int TAN_PREC      = MAX_FRAC_BITS + 1;
   localparam int FD_W          = 64 + TAN_PREC;

   localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
   localparam logic [63:0] ONE_Q60 = 64'd1 << 60;
   localparam logic [63:0] RAD_PER_DEG_Q60 = (PI_Q60 + 64'd90) / 64'd180;

   typedef struct packed {
      logic signed [7:0]  steering_deg;
      logic signed [15:0] speed_dps;
   } req_type;

   typedef struct packed {
      logic signed [15:0] left_speed;
      logic signed [15:0] right_speed;
   } rsp_type;

   typedef enum logic [2:0] {
      CLS_STRAIGHT,
      CLS_SPIN_NEG,
      CLS_SPIN_POS,
      CLS_TURN_POS,
      CLS_TURN_NEG
   } steer_class_type;

   // Fields that ride alongside the divider.
   typedef struct packed {
      steer_class_type    steer_class;
      logic               num_neg;
      logic               den_zero;
      logic signed [15:0] speed_dps;
   } side_type;

   // (a * b) >> 60 on Q60 values below 2^62.
   function automatic logic [63:0] mul60(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[123:60];
   endfunction

   // Floor division of a 64-bit value by a small divisor, bit by bit.
   function automatic logic [63:0] div_small(input logic [63:0] n, input logic [15:0] d);
      logic [63:0] q;
      logic [16:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[15:0], n[i]};
         if (r >= {1'b0, d}) begin
            r    = r - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // Q60 sine and cosine of k degrees (k at most 45), packed as {sine, cosine}.
   function automatic logic [127:0] sin_cos(input logic [6:0] k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] ts;
      logic [63:0] tc;
      logic [63:0] sv;
      logic [63:0] cv;
      x  = RAD_PER_DEG_Q60 * {57'd0, k};
      x2 = mul60(x, x);
      ts = x;
      tc = ONE_Q60;
      sv = x;
      cv = ONE_Q60;
      for (int n = 1; n <= 12; n++) begin
         ts = div_small(mul60(ts, x2), 16'((2 * n) * (2 * n + 1)));
         tc = div_small(mul60(tc, x2), 16'((2 * n - 1) * (2 * n)));
         if ((n & 1) == 1) begin
            sv = sv - ts;
            cv = cv - tc;
         end else begin
            sv = sv + ts;
            cv = cv + tc;
         end
      end
      return {sv, cv};
   endfunction

   // floor(n * 2^TAN_PREC / d) by restoring long division.
   function automatic logic [FD_W-1:0] frac_div(input logic [63:0] n, input logic [63:0] d);
      logic [FD_W-1:0] num;
      logic [FD_W-1:0] q;
      logic [64:0]     r;
      num = {n, TAN_PREC'(0)};
      q   = '0;
      r   = '0;
      for (int i = FD_W - 1; i >= 0; i--) begin
         r = {r[63:0], num[i]};
         if (r >= {1'b0, d}) begin
            r    = r - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // |tan(m degrees)| with frac_bits fraction bits, rounded half up (1 <= m <= 89).
   function automatic logic [31:0] tan_q(input logic [6:0] m, input int frac_bits);
      logic [127:0]    scv;
      logic [FD_W-1:0] q;
      if (m <= 7'd45) begin
         scv = sin_cos(m);
         q   = frac_div(scv[127:64], scv[63:0]);
      end else begin
         scv = sin_cos(7'(7'd90 - m));
         q   = frac_div(scv[63:0], scv[127:64]);
      end
      q = q >> (MAX_FRAC_BITS - frac_bits);
      q = (q + FD_W'(1)) >> 1;
      return q[31:0];
   endfunction

endpackage

### rtl/differential_steering_mixer.sv
// Top level of the differential steering mixer: request pipeline, ratio divider and scaling.
//
// The mixer turns a steering angle in whole degrees and a common speed setpoint into
// left and right wheel speed setpoints. It is fully pipelined: while busy is low, a new
// request may be issued on every clock cycle, and each result appears on rsp_data with
// rsp_valid high for exactly one cycle. Each request passes through the ratio divider,
// which resolves one quotient bit per pipeline stage over FRAC_BITS + 1 stages, and
// through five stages for angle decode and table lookup, the two base products,
// the sum and difference, the speed multiply and the final rounding. Results come
// out in request order and cannot be held off, so the receiver must take each one
// in the cycle it is shown. The busy output is high only during reset and for the
// first cycle after it; there is no clearing pass. The wheel_length and axle_length
// registers are written through the csr_ channel, which is always ready; change them
// only while no request is in flight.
`include "differential_steering_mixer_defines.svh"

module differential_steering_mixer #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                start,
   output logic                                busy,
   input  dsm_pkg::req_type                    req_data,
   // Result channel.
   output logic                                rsp_valid,
   output dsm_pkg::rsp_type                    rsp_data,
   // Configuration register writes.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dsm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dsm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // Width plan. The tangent reaches about 57.3, so it needs six integer bits. Pi in
   // fixed point needs two. The turning base P is wheel_length times pi, the offset is
   // half the axle length times the tangent, and their sum is the divider's width.
   localparam int TAN_W   = FRAC_BITS + 6;
   localparam int PI_W    = FRAC_BITS + 2;
   localparam int P_W     = dsm_pkg::CSR_DATA_W + PI_W;
   localparam int HT_W    = dsm_pkg::CSR_DATA_W - 1 + TAN_W;
   localparam int DEN_W   = FRAC_BITS + 18;
   localparam int RAT_W   = FRAC_BITS + 2;
   localparam int PROD_W  = 16 + RAT_W;
   localparam int V_W     = PROD_W - FRAC_BITS;
   localparam int LATENCY = FRAC_BITS + 6;

   // Pi rounded half up to the working fraction.
   localparam logic [63:0] PI_ROUND =
      (dsm_pkg::PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
   localparam logic [PI_W-1:0] PI_F = PI_ROUND[PI_W-1:0];

   localparam logic signed [RAT_W-1:0]  RATIO_ONE  = RAT_W'(64'd1 << FRAC_BITS);
   localparam logic [PROD_W-1:0]        ROUND_BIAS = PROD_W'((64'd1 << FRAC_BITS) - 64'd1);
   localparam logic signed [V_W-1:0]    V_MAX      = V_W'(dsm_pkg::SPEED_MAX);
   localparam logic signed [V_W-1:0]    V_MIN      = V_W'(dsm_pkg::SPEED_MIN);

   // ------------------------------------------------------------------------------
   // Tangent table, built at elaboration. Entries for straight ahead and for the two
   // spin angles are never used and hold zero.
   // ------------------------------------------------------------------------------
   logic [TAN_W-1:0] tan_rom [dsm_pkg::TAN_DEPTH];

   for (genvar g = 0; g < dsm_pkg::TAN_DEPTH; g++) begin : g_tan
      localparam logic [31:0] TAN_VAL = (g == 0 || g == dsm_pkg::TAN_DEPTH - 1) ? 32'd0 :
                                        dsm_pkg::tan_q(7'(g), FRAC_BITS);
      assign tan_rom[g] = TAN_VAL[TAN_W-1:0];
   end

   // ------------------------------------------------------------------------------
   // Configuration registers. The port always takes a write; an index past the
   // register list is ignored.
   // ------------------------------------------------------------------------------
   logic [dsm_pkg::CSR_DATA_W-1:0] wheel_length_ff;
   logic [dsm_pkg::CSR_DATA_W-1:0] wheel_length_in;
   logic [dsm_pkg::CSR_DATA_W-1:0] axle_length_ff;
   logic [dsm_pkg::CSR_DATA_W-1:0] axle_length_in;

   assign csr_ready = 1'b1;

   always_comb begin
      wheel_length_in = wheel_length_ff;
      axle_length_in  = axle_length_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dsm_pkg::CSR_WHEEL_LENGTH: wheel_length_in = csr_wdata;
            dsm_pkg::CSR_AXLE_LENGTH:  axle_length_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wheel_length_ff <= dsm_pkg::WHEEL_LENGTH_RESET;
         axle_length_ff  <= dsm_pkg::AXLE_LENGTH_RESET;
      end else begin
         wheel_length_ff <= wheel_length_in;
         axle_length_ff  <= axle_length_in;
      end
   end

   // The pipeline takes a request every cycle that busy is low; busy is set by reset and clears once reset is released.
   logic busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy = busy_ff;

   // ------------------------------------------------------------------------------
   // Stage A: saturate the angle, classify it and look up the tangent magnitude.
   // ------------------------------------------------------------------------------
   logic signed [7:0]                 steer;
   dsm_pkg::steer_class_type          cls_in;
   logic [dsm_pkg::TAN_IDX_W-1:0]     mag_in;

   logic                              valid_a_ff;
   dsm_pkg::steer_class_type          cls_a_ff;
   logic signed [15:0]                speed_a_ff;
   logic [TAN_W-1:0]                  tan_a_ff;

   assign steer = req_data.steering_deg;

   always_comb begin
      cls_in = dsm_pkg::CLS_STRAIGHT;
      mag_in = '0;
      if (steer >= dsm_pkg::STEER_MAX) begin
         cls_in = dsm_pkg::CLS_SPIN_POS;
      end else if (steer <= dsm_pkg::STEER_MIN) begin
         cls_in = dsm_pkg::CLS_SPIN_NEG;
      end else if (steer == 8'sd0) begin
         cls_in = dsm_pkg::CLS_STRAIGHT;
      end else if (steer[7]) begin
         // Between minus 89 and minus 1, so the negation fits.
         cls_in = dsm_pkg::CLS_TURN_NEG;
         mag_in = dsm_pkg::TAN_IDX_W'(-steer);
      end else begin
         cls_in = dsm_pkg::CLS_TURN_POS;
         mag_in = dsm_pkg::TAN_IDX_W'(steer);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= start && !busy;
      end
      cls_a_ff   <= cls_in;
      speed_a_ff <= req_data.speed_dps;
      tan_a_ff   <= tan_rom[mag_in];
   end

   // ------------------------------------------------------------------------------
   // Stage B: turning base P = wheel_length * pi and offset h * |t|, h = axle / 2.
   // ------------------------------------------------------------------------------
   logic                     valid_b_ff;
   dsm_pkg::steer_class_type cls_b_ff;
   logic signed [15:0]       speed_b_ff;
   logic [P_W-1:0]           p_b_ff;
   logic [HT_W-1:0]          ht_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else begin
         valid_b_ff <= valid_a_ff;
      end
      cls_b_ff   <= cls_a_ff;
      speed_b_ff <= speed_a_ff;
      p_b_ff     <= wheel_length_ff * PI_F;
      ht_b_ff    <= axle_length_ff[dsm_pkg::CSR_DATA_W-1:1] * tan_a_ff;
   end

   // ------------------------------------------------------------------------------
   // Stage C: numerator P - h|t| as sign and magnitude, denominator P + h|t|. Both
   // turn directions divide the same pair; only the wheel that takes the ratio differs.
   // ------------------------------------------------------------------------------
   logic [DEN_W-1:0]   p_ext;
   logic [DEN_W-1:0]   ht_ext;
   logic               num_neg_in;
   logic [DEN_W-1:0]   num_in;
   logic [DEN_W-1:0]   den_in;

   logic               valid_c_ff;
   logic [DEN_W-1:0]   num_c_ff;
   logic [DEN_W-1:0]   den_c_ff;
   dsm_pkg::side_type  side_c_ff;

   assign p_ext      = DEN_W'(p_b_ff);
   assign ht_ext     = DEN_W'(ht_b_ff);
   assign num_neg_in = (ht_ext > p_ext);
   assign num_in     = num_neg_in ? (ht_ext - p_ext) : (p_ext - ht_ext);
   assign den_in     = p_ext + ht_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_c_ff <= 1'b0;
      end else begin
         valid_c_ff <= valid_b_ff;
      end
      num_c_ff              <= num_in;
      den_c_ff              <= den_in;
      side_c_ff.steer_class <= cls_b_ff;
      side_c_ff.num_neg     <= num_neg_in;
      side_c_ff.den_zero    <= (p_b_ff == '0) && (ht_b_ff == '0);
      side_c_ff.speed_dps   <= speed_b_ff;
   end

   // ------------------------------------------------------------------------------
   // Ratio divider: floor(|num| * 2^FRAC_BITS / den), at most one in fixed point.
   // ------------------------------------------------------------------------------
   logic               div_valid;
   logic [FRAC_BITS:0] div_quot;
   dsm_pkg::side_type  div_side;

   dsm_div_pipe #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_c_ff),
      .in_num    (num_c_ff),
      .in_den    (den_c_ff),
      .in_side   (side_c_ff),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_side  (div_side)
   );

   // ------------------------------------------------------------------------------
   // Stage D: pick each wheel's ratio and multiply it by the speed setpoint.
   // ------------------------------------------------------------------------------
   logic signed [RAT_W-1:0]  ratio_turn;
   logic signed [RAT_W-1:0]  ratio_l;
   logic signed [RAT_W-1:0]  ratio_r;
   logic signed [PROD_W-1:0] prod_l_in;
   logic signed [PROD_W-1:0] prod_r_in;

   logic                     valid_d_ff;
   logic signed [PROD_W-1:0] prod_l_ff;
   logic signed [PROD_W-1:0] prod_r_ff;

   always_comb begin
      // A zero divisor only happens with a zero wheel size and no offset; the ratio
      // is then taken as one.
      if (div_side.den_zero) begin
         ratio_turn = RATIO_ONE;
      end else if (div_side.num_neg) begin
         ratio_turn = -$signed({1'b0, div_quot});
      end else begin
         ratio_turn = $signed({1'b0, div_quot});
      end

      unique case (div_side.steer_class)
         dsm_pkg::CLS_STRAIGHT: begin
            ratio_l = RATIO_ONE;
            ratio_r = RATIO_ONE;
         end
         dsm_pkg::CLS_SPIN_NEG: begin
            ratio_l = RATIO_ONE;
            ratio_r = -RATIO_ONE;
         end
         dsm_pkg::CLS_SPIN_POS: begin
            ratio_l = -RATIO_ONE;
            ratio_r = RATIO_ONE;
         end
         dsm_pkg::CLS_TURN_POS: begin
            ratio_l = ratio_turn;
            ratio_r = RATIO_ONE;
         end
         dsm_pkg::CLS_TURN_NEG: begin
            ratio_l = RATIO_ONE;
            ratio_r = ratio_turn;
         end
         default: begin
            ratio_l = RATIO_ONE;
            ratio_r = RATIO_ONE;
         end
      endcase

      prod_l_in = $signed(div_side.speed_dps) * ratio_l;
      prod_r_in = $signed(div_side.speed_dps) * ratio_r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_d_ff <= 1'b0;
      end else begin
         valid_d_ff <= div_valid;
      end
      prod_l_ff <= prod_l_in;
      prod_r_ff <= prod_r_in;
   end

   // ------------------------------------------------------------------------------
   // Stage E: drop the fraction toward zero and saturate. Only minus full scale
   // times minus one can exceed the 16-bit range.
   // ------------------------------------------------------------------------------
   function automatic logic signed [15:0] to_speed(input logic signed [PROD_W-1:0] prod);
      logic signed [PROD_W-1:0] sum;
      logic signed [V_W-1:0]    v;
      sum = prod + (prod[PROD_W-1] ? $signed(ROUND_BIAS) : $signed(PROD_W'(0)));
      v   = sum[PROD_W-1:FRAC_BITS];
      if (v > V_MAX) begin
         return 16'(V_MAX);
      end else if (v < V_MIN) begin
         return 16'(V_MIN);
      end
      return v[15:0];
   endfunction

   logic             rsp_valid_ff;
   dsm_pkg::rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_d_ff;
      end
      rsp_data_ff.left_speed  <= to_speed(prod_l_ff);
      rsp_data_ff.right_speed <= to_speed(prod_r_ff);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------------
   // Every accepted request produces its result after the fixed pipeline latency.
   `DSM_ASSERT_LATER(a_rsp_latency, LATENCY, start && !busy, rsp_valid, "result missing after request")
   // No result appears without a request accepted exactly one latency earlier.
   `DSM_ASSERT_IMPL(a_rsp_origin, rsp_valid, $past(start && !busy, LATENCY), "result without request")
   // With a nonzero divisor the ratio magnitude never exceeds one.
   `DSM_ASSERT_IMPL(a_ratio_bound, div_valid && !div_side.den_zero, div_quot <= (FRAC_BITS + 1)'(RATIO_ONE), "ratio above one")

endmodule

### rtl/dsm_div_pipe.sv
// Pipelined restoring divider: one quotient bit per stage, sideband carried along.
module dsm_div_pipe #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [FRAC_BITS+17:0] in_num,
   input  logic [FRAC_BITS+17:0] in_den,
   input  dsm_pkg::side_type     in_side,
   output logic                  out_valid,
   output logic [FRAC_BITS:0]    out_quot,
   output dsm_pkg::side_type     out_side
);

   localparam int DEN_W = FRAC_BITS + 18;
   localparam int Q_W   = FRAC_BITS + 1;
   localparam int STEPS = FRAC_BITS + 1;

   logic              valid_ff [STEPS];
   logic [DEN_W-1:0]  rem_ff   [STEPS];
   logic [DEN_W-1:0]  den_ff   [STEPS];
   logic [Q_W-1:0]    quot_ff  [STEPS];
   dsm_pkg::side_type side_ff  [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic              src_valid;
      logic [DEN_W-1:0]  src_den;
      logic [Q_W-1:0]    src_quot;
      dsm_pkg::side_type src_side;
      logic [DEN_W:0]    trial;
      logic [DEN_W:0]    diff;
      logic              take;
      logic [DEN_W-1:0]  rem_in;

      // The first step sees the numerator itself; later steps see the
      // previous remainder shifted up by one bit.
      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_den   = in_den;
         assign src_quot  = '0;
         assign src_side  = in_side;
         assign trial     = {1'b0, in_num};
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_den   = den_ff[k-1];
         assign src_quot  = quot_ff[k-1];
         assign src_side  = side_ff[k-1];
         assign trial     = {rem_ff[k-1], 1'b0};
      end

      assign diff   = trial - {1'b0, src_den};
      assign take   = (trial >= {1'b0, src_den});
      assign rem_in = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= src_valid;
         end
         rem_ff[k]  <= rem_in;
         den_ff[k]  <= src_den;
         quot_ff[k] <= {src_quot[Q_W-2:0], take};
         side_ff[k] <= src_side;
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_quot  = quot_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

### test/differential_steering_mixer_tb.sv
// Self-checking testbench for the differential steering mixer: directed cases, then random requests.
module differential_steering_mixer_tb;
   import dsm_pkg::*;

   // The fraction width that the mixer is built with. The predictor uses the same width.
   localparam int FRAC_BITS = 16;
   // Request to result latency as the block defines it. It is used only for the final settle time.
   localparam int LATENCY = FRAC_BITS + 6;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_COUNT = 11;
   localparam int REQUESTS_PER_PHASE = 60;
   // A register index past the end of the list. A write to it must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 4'd9;

   localparam logic signed [15:0] SPEED_LOW  = 16'sh8000;
   localparam logic signed [15:0] SPEED_HIGH = 16'sh7fff;

   // Fixed-point constants: pi in Q60, radians per degree in Q60, and one in Q60.
   localparam logic [63:0] ANGLE_PI_Q60   = 64'h3243F6A8885A308D;
   localparam logic [63:0] UNIT_Q60       = 64'd1 << 60;
   localparam logic [63:0] RAD_PER_DEGREE = (ANGLE_PI_Q60 + 64'd90) / 64'd180;
   // Pi rounded half up to the ratio's fraction width, and one in that width.
   localparam longint PI_QF  = longint'((ANGLE_PI_Q60 + (64'd1 << (59 - FRAC_BITS)))
                                        >> (60 - FRAC_BITS));
   localparam longint ONE_QF = longint'(1) << FRAC_BITS;

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_data;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // This is the testbench's own copy of the two geometry registers.
   logic [11:0]      wheel_length_q;
   logic [11:0]      axle_length_q;

   // Each accepted request adds the wheel speeds it should produce. They are kept in request order.
   rsp_type          pending_wheel_speeds[$];
   int               mismatch_count = 0;
   int               results_checked = 0;
   int               requests_sent = 0;
   int               cycle_count = 0;

   differential_steering_mixer #(
      .FRAC_BITS(FRAC_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Wheel speed predictor.
   // ---------------------------------------------------------------------------------------

   // Returns (a * b) >> 60 for Q60 operands.
   function automatic logic [63:0] q60_product(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] wide;
      wide = {64'd0, a} * {64'd0, b};
      return wide[123:60];
   endfunction

   // Returns floor(n * 2^bits / d). The callers keep the quotient well inside 64 bits.
   function automatic logic [63:0] scaled_quotient(input logic [63:0] n, input logic [63:0] d,
                                                    input int bits);
      logic [127:0] wide;
      wide = ({64'd0, n} << bits) / {64'd0, d};
      return wide[63:0];
   endfunction

   // Computes the Q60 sine and cosine of k degrees, with k at most 45, from thirteen Taylor terms.
   // Each term is divided down separately. That matches the truncation of the block.
   function automatic void taylor_sin_cos(input int unsigned k, output logic [63:0] sine,
                                          output logic [63:0] cosine);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] sine_term;
      logic [63:0] cosine_term;
      x = 64'(k) * RAD_PER_DEGREE;
      x2 = q60_product(x, x);
      sine_term = x;
      cosine_term = UNIT_Q60;
      sine = x;
      cosine = UNIT_Q60;
      for (int n = 1; n <= 12; n++) begin
         sine_term = q60_product(sine_term, x2) / 64'((2 * n) * (2 * n + 1));
         cosine_term = q60_product(cosine_term, x2) / 64'((2 * n - 1) * (2 * n));
         if (n % 2 == 1) begin
            sine = sine - sine_term;
            cosine = cosine - cosine_term;
         end else begin
            sine = sine + sine_term;
            cosine = cosine + cosine_term;
         end
      end
   endfunction

   // Returns |tan(m degrees)| for 1 <= m <= 89. It is formed with one extra fraction bit
   // and then rounded half up. Above 45 degrees it uses the complement angle.
   function automatic logic [63:0] tan_magnitude(input int unsigned m);
      logic [63:0] sine;
      logic [63:0] cosine;
      logic [63:0] q;
      if (m <= 45) begin
         taylor_sin_cos(m, sine, cosine);
         q = scaled_quotient(sine, cosine, FRAC_BITS + 1);
      end else begin
         taylor_sin_cos(90 - m, sine, cosine);
         q = scaled_quotient(cosine, sine, FRAC_BITS + 1);
      end
      return (q + 64'd1) >> 1;
   endfunction

   // Returns num / den in the ratio format, truncated toward zero. A zero divisor gives a ratio of one.
   function automatic longint wheel_ratio(input longint num, input longint den);
      longint mag;
      if (den == 0)
         return ONE_QF;
      mag = longint'(scaled_quotient(64'(num < 0 ? -num : num), 64'(den < 0 ? -den : den),
                                     FRAC_BITS));
      return ((num < 0) != (den < 0)) ? -mag : mag;
   endfunction

   // Returns speed times ratio, truncated toward zero and clamped to 16 bits.
   // The clamp matters only for -32768 times -1.
   function automatic logic signed [15:0] scaled_speed(input longint speed, input longint ratio);
      longint product;
      longint mag;
      longint value;
      product = speed * ratio;
      mag = (product < 0 ? -product : product) >> FRAC_BITS;
      value = product < 0 ? -mag : mag;
      if (value > 32767)
         value = 32767;
      if (value < -32768)
         value = -32768;
      return 16'(value);
   endfunction

   // Predicts both wheel speeds for one request under the current register settings.
   function automatic rsp_type mix_wheel_speeds(input req_type request);
      rsp_type speeds;
      int      angle;
      longint  base;
      longint  lateral;
      longint  left_ratio;
      longint  right_ratio;
      angle = int'(request.steering_deg);
      if (angle > 90)
         angle = 90;
      if (angle < -90)
         angle = -90;
      if (angle == 0) begin
         left_ratio = ONE_QF;
         right_ratio = ONE_QF;
      end else if (angle == -90) begin
         left_ratio = ONE_QF;
         right_ratio = -ONE_QF;
      end else if (angle == 90) begin
         left_ratio = -ONE_QF;
         right_ratio = ONE_QF;
      end else begin
         // The turning base is wheel_length * pi. The lateral term is half the axle
         // times |tan|. The wheel on the inside of the turn gets (base - lateral) /
         // (base + lateral). The wheel on the outside keeps the full speed.
         base = longint'(wheel_length_q) * PI_QF;
         lateral = longint'(axle_length_q >> 1)
                   * longint'(tan_magnitude(angle < 0 ? -angle : angle));
         if (angle > 0) begin
            left_ratio = wheel_ratio(base - lateral, base + lateral);
            right_ratio = ONE_QF;
         end else begin
            left_ratio = ONE_QF;
            right_ratio = wheel_ratio(base - lateral, base + lateral);
         end
      end
      speeds.left_speed = scaled_speed(longint'(request.speed_dps), left_ratio);
      speeds.right_speed = scaled_speed(longint'(request.speed_dps), right_ratio);
      return speeds;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Request side.
   // ---------------------------------------------------------------------------------------

   // Presents one request and waits for the edge that accepts it. Start is left high, so a
   // request that follows at once goes out in the next cycle. A gap lowers start on its own.
   // The predicted result joins the queue at the accepting edge.
   task automatic send_request(input req_type request, input rsp_type predicted);
      start <= 1'b1;
      req_data <= request;
      do
         @(posedge clock);
      while (busy);
      pending_wheel_speeds.push_back(predicted);
      requests_sent++;
   endtask

   // Lowers start and idles for the given number of cycles. A gap of zero leaves start high.
   task automatic idle_requests(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Stops sending and waits until every outstanding result has come back.
   // The wait always covers at least one edge. That keeps the lowering of start and
   // any later raising of it in separate steps.
   task automatic drain_pipeline();
      start <= 1'b0;
      do
         @(posedge clock);
      while (pending_wheel_speeds.size() != 0);
   endtask

   // Writes one register over the csr channel and updates the local copy.
   // csr_valid stays high, so several writes in a row use adjacent cycles.
   // The caller lowers csr_valid after the last write.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      if (index == CSR_WHEEL_LENGTH)
         wheel_length_q = value;
      else if (index == CSR_AXLE_LENGTH)
         axle_length_q = value;
   endtask

   // Draws one random request. Most angles are inside the legal range. Some land on the fixed
   // cases and their neighbors. Some use the full 8-bit field to exercise the saturation.
   // Most speeds are uniform over 16 bits. A few sit on the extremes.
   function automatic req_type random_request();
      req_type request;
      int      pick;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         case ($urandom_range(0, 6))
            0:       request.steering_deg = 8'sd0;
            1:       request.steering_deg = 8'sd90;
            2:       request.steering_deg = -8'sd90;
            3:       request.steering_deg = 8'sd1;
            4:       request.steering_deg = -8'sd1;
            5:       request.steering_deg = 8'sd89;
            default: request.steering_deg = -8'sd89;
         endcase
      end else if (pick < 85) begin
         request.steering_deg = 8'($signed($urandom_range(0, 180)) - 90);
      end else begin
         request.steering_deg = 8'($urandom_range(0, 255));
      end
      case ($urandom_range(0, 11))
         0:       request.speed_dps = SPEED_LOW;
         1:       request.speed_dps = SPEED_HIGH;
         2:       request.speed_dps = 16'($signed($urandom_range(0, 20)) - 10);
         default: request.speed_dps = 16'($urandom_range(0, 65535));
      endcase
      return request;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Directed cases. They run at the reset geometry: wheel_length 56 and axle_length 120.
   // Where a row gives the result, that value is checked. Otherwise the predictor supplies it.
   // ---------------------------------------------------------------------------------------

   typedef struct packed {
      logic signed [7:0]  steering_deg;
      logic signed [15:0] speed_dps;
      logic               has_typed_result;
      logic signed [15:0] left_speed;
      logic signed [15:0] right_speed;
   } steering_case_type;

   localparam int DIRECTED_COUNT = 23;

   steering_case_type steering_cases[DIRECTED_COUNT] = '{
      // Straight ahead passes the speed through on both wheels, including the extremes.
      '{ 8'sd0,     16'sd1000,   1'b1,  16'sd1000,   16'sd1000},
      '{ 8'sd0,     SPEED_LOW,   1'b1,  SPEED_LOW,   SPEED_LOW},
      '{ 8'sd0,     SPEED_HIGH,  1'b1,  SPEED_HIGH,  SPEED_HIGH},
      '{ 8'sd0,     16'sd0,      1'b1,  16'sd0,      16'sd0},
      // Spin in place. At the low speed extreme, the negated wheel saturates.
      '{-8'sd90,    16'sd1000,   1'b1,  16'sd1000,  -16'sd1000},
      '{ 8'sd90,    16'sd1000,   1'b1, -16'sd1000,   16'sd1000},
      '{ 8'sd90,    SPEED_LOW,   1'b1,  SPEED_HIGH,  SPEED_LOW},
      '{-8'sd90,    SPEED_LOW,   1'b1,  SPEED_LOW,   SPEED_HIGH},
      '{ 8'sd90,    SPEED_HIGH,  1'b1, -16'sd32767,  SPEED_HIGH},
      // Angles beyond the range behave as a full spin.
      '{ 8'sd127,   16'sd500,    1'b1, -16'sd500,    16'sd500},
      '{-8'sd128,   16'sd500,    1'b1,  16'sd500,   -16'sd500},
      '{ 8'sd91,    16'sd7,      1'b1, -16'sd7,      16'sd7},
      '{-8'sd91,    16'sd7,      1'b1,  16'sd7,     -16'sd7},
      // Ordinary turns at the edges of the tangent table and in between.
      '{ 8'sd1,     16'sd30000,  1'b0,  16'sd0,      16'sd0},
      '{-8'sd1,     16'sd30000,  1'b0,  16'sd0,      16'sd0},
      '{ 8'sd45,   -16'sd20000,  1'b0,  16'sd0,      16'sd0},
      '{-8'sd45,   -16'sd20000,  1'b0,  16'sd0,      16'sd0},
      '{ 8'sd89,    SPEED_HIGH,  1'b0,  16'sd0,      16'sd0},
      '{-8'sd89,    SPEED_HIGH,  1'b0,  16'sd0,      16'sd0},
      '{ 8'sd89,    SPEED_LOW,   1'b0,  16'sd0,      16'sd0},
      '{ 8'sd30,    16'sd1234,   1'b0,  16'sd0,      16'sd0},
      '{-8'sd60,   -16'sd4321,   1'b0,  16'sd0,      16'sd0},
      '{ 8'sd1,    -16'sd1,      1'b0,  16'sd0,      16'sd0}
   };

   // ---------------------------------------------------------------------------------------
   // Result checking. Each strobe is compared with the oldest prediction. The block cannot
   // hold results back, so every cycle with rsp_valid high is one result.
   // ---------------------------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_type predicted;
      if (!reset && rsp_valid) begin
         if (pending_wheel_speeds.size() == 0) begin
            $error("unexpected result: left_speed %0d, right_speed %0d",
                   rsp_data.left_speed, rsp_data.right_speed);
            mismatch_count++;
         end else begin
            predicted = pending_wheel_speeds.pop_front();
            results_checked++;
            if (rsp_data.left_speed !== predicted.left_speed) begin
               $error("left_speed: expected %0d, got %0d",
                      predicted.left_speed, rsp_data.left_speed);
               mismatch_count++;
            end
            if (rsp_data.right_speed !== predicted.right_speed) begin
               $error("right_speed: expected %0d, got %0d",
                      predicted.right_speed, rsp_data.right_speed);
               mismatch_count++;
            end
         end
      end
   end

   // This watchdog ends a run that hangs on a handshake that never completes.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus sequence.
   // ---------------------------------------------------------------------------------------

   initial begin
      req_type     request;
      rsp_type     predicted;
      logic [11:0] wheel_setting;
      logic [11:0] axle_setting;
      int          burst_left;

      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      wheel_length_q = WHEEL_LENGTH_RESET;
      axle_length_q = AXLE_LENGTH_RESET;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // The directed cases go out back to back. The first one also waits out the busy cycle after reset.
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         request.steering_deg = steering_cases[i].steering_deg;
         request.speed_dps = steering_cases[i].speed_dps;
         if (steering_cases[i].has_typed_result) begin
            predicted.left_speed = steering_cases[i].left_speed;
            predicted.right_speed = steering_cases[i].right_speed;
         end else begin
            predicted = mix_wheel_speeds(request);
         end
         send_request(request, predicted);
      end

      // In each phase, the pipeline drains first. A new geometry is then written, and random
      // requests go out in bursts. The first phase keeps the reset geometry. The next ones cover
      // both 12-bit extremes. They also cover a zero wheel length. With a zero half-axle, that
      // gives a zero divisor. With a nonzero half-axle, it gives a ratio of minus one.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain_pipeline();
         if (phase > 0) begin
            case (phase)
               1:       begin wheel_setting = 12'd4095; axle_setting = 12'd4095; end
               2:       begin wheel_setting = 12'd1;    axle_setting = 12'd0;    end
               3:       begin wheel_setting = 12'd0;    axle_setting = 12'd0;    end
               4:       begin wheel_setting = 12'd0;    axle_setting = 12'd1;    end
               5:       begin wheel_setting = 12'd0;    axle_setting = 12'd4095; end
               6:       begin wheel_setting = 12'd4095; axle_setting = 12'd0;    end
               7:       begin wheel_setting = 12'd1;    axle_setting = 12'd4095; end
               10:      begin wheel_setting = WHEEL_LENGTH_RESET;
                              axle_setting = AXLE_LENGTH_RESET; end
               default: begin wheel_setting = 12'($urandom_range(1, 4095));
                              axle_setting = 12'($urandom_range(0, 4095)); end
            endcase
            write_register(CSR_WHEEL_LENGTH, wheel_setting);
            write_register(CSR_AXLE_LENGTH, axle_setting);
            // A write past the register list must leave both lengths as they are.
            if (phase == 8)
               write_register(CSR_SPARE_INDEX, 12'($urandom_range(0, 4095)));
            csr_valid <= 1'b0;
         end

         burst_left = $urandom_range(1, 24);
         for (int n = 0; n < REQUESTS_PER_PHASE; n++) begin
            request = random_request();
            send_request(request, mix_wheel_speeds(request));
            burst_left--;
            if (burst_left == 0) begin
               // About a quarter of the bursts run straight into the next one.
               // That gives long stretches with no idle cycles.
               if ($urandom_range(0, 3) != 0)
                  idle_requests($urandom_range(1, 6));
               burst_left = $urandom_range(1, 24);
            end
         end
      end

      // Wait for the last results, then give stray strobes time to show up.
      drain_pipeline();
      repeat (2 * LATENCY) @(posedge clock);

      $display("Checked %0d results from %0d requests over %0d geometry settings.",
               results_checked, requests_sent, PHASE_COUNT);
      $display("The settings included both length extremes, a zero wheel length and a spare index.");
      if (mismatch_count == 0 && pending_wheel_speeds.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/dsm_pkg.sv
rtl/dsm_div_pipe.sv
rtl/differential_steering_mixer.sv
test/differential_steering_mixer_tb.sv
